FILE: design/vpvs_pkg.sv
// ============================================================================
// vpvs_pkg: shared types, constants and helpers for vp_to_vs_and_density
// Holds the polynomial coefficients in scaled integer form, the divisor
// constants and the split-multiply helpers used by the Horner stages.
// ============================================================================
package vpvs_pkg;

  // Quotient bits produced by each constant divider.
  localparam int unsigned QW = 18;
  // Register stages in one constant divider.
  localparam int unsigned DIV_LAT = 4;

  // Input velocity limit in m/s.
  localparam logic signed [15:0] VP_LIMIT = 16'sd16383;
  localparam logic [13:0] VP_LIMIT_U = 14'd16383;

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_FIELD_W = 19;
  localparam int unsigned OUT_TDATA_W = 40;

  // Density floor in kg/m^3.
  localparam logic [OUT_FIELD_W-1:0] RHO_FLOOR = 19'd1000;
  localparam logic [QW-1:0] RHO_FLOOR_Q = 18'd1000;

  // Horner accumulator and full product types.
  typedef logic signed [63:0] acc_t;
  typedef logic signed [78:0] prod_t;
  typedef logic [45:0]        pp_lo_t;
  typedef logic signed [46:0] pp_hi_t;

  // Leading terms of the two polynomials in integer m/s.
  localparam acc_t C_A1 = 64'sd1238000;
  localparam acc_t C_T1 = 64'sd4300000;

  // Constants added after each multiply-by-v step. The S-wave chain carries
  // the rounding half of 1e13 in its last constant.
  localparam acc_t C_A [3] = '{
    64'sd7949000000,
    -64'sd12344000000000,
    64'sd7863000000000000
  };
  localparam acc_t C_D [3] = '{
    64'sd67100000000,
    -64'sd472100000000000,
    64'sd1661200000000000000
  };

  // Rounding half for the density quotient.
  localparam logic [79:0] C_RHO_HALF = 80'd500000000000000000;

  // Divisors: the S-wave numerator is scaled by 1e13 = 2^13 * 5^13 and the
  // density numerator by 1e18 = 2^18 * 5^18. Each divider shifts out the
  // power of two and divides by the odd part.
  localparam int unsigned DIV_VS_SH   = 13;
  localparam logic [63:0] DIV_VS_ODD  = 64'd1220703125;
  localparam int unsigned DIV_RHO_SH  = 18;
  localparam logic [63:0] DIV_RHO_ODD = 64'd3814697265625;

  // Low partial product: v times the low 32 bits of x, unsigned.
  function automatic pp_lo_t pp_lo(logic [13:0] v, acc_t x);
    return 46'(v) * 46'(x[31:0]);
  endfunction

  // High partial product: v times the signed upper 32 bits of x.
  function automatic pp_hi_t pp_hi(logic [13:0] v, acc_t x);
    return 47'(signed'({1'b0, v})) * 47'(signed'(x[63:32]));
  endfunction

  // Recombine the two partial products into the full signed product.
  function automatic prod_t pp_sum(pp_hi_t hi, pp_lo_t lo);
    return (prod_t'(hi) <<< 32) + prod_t'({1'b0, lo});
  endfunction

endpackage

FILE: design/vpvs_cdiv.sv
// ============================================================================
// vpvs_cdiv: pipelined division by a constant
// Divides an unsigned numerator by DIV_ODD * 2^SH in four register stages.
// The power of two is a shift; the odd part uses a reciprocal multiply that
// lands at most two below the true quotient, followed by a remainder
// correction. A quotient that needs more than QW bits saturates to all ones.
// ============================================================================
module vpvs_cdiv #(
  parameter int unsigned W       = 64,
  parameter int unsigned SH      = 13,
  parameter logic [63:0] DIV_ODD = 64'd1220703125
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [W-1:0]            n_i,
  output logic [vpvs_pkg::QW-1:0] q_o
);
  import vpvs_pkg::*;

  // Width of the odd divisor. A shifted numerator below 2^MW keeps the
  // quotient within QW + 1 bits, and the remainder stays below 2^RW.
  localparam int unsigned DW  = $clog2(DIV_ODD);
  localparam int unsigned MW  = DW + QW;
  localparam int unsigned RW  = DW + 2;
  localparam int unsigned RCW = QW + 1;

  localparam logic [63:0]    RECIP64 = (64'd1 << MW) / DIV_ODD;
  localparam logic [RCW-1:0] RECIP   = RCW'(RECIP64);
  localparam logic [31:0]    D_LO    = DIV_ODD[31:0];
  localparam logic [31:0]    D_HI    = DIV_ODD[63:32];
  localparam logic [RW-1:0]  D1      = RW'(DIV_ODD);
  localparam logic [RW-1:0]  D2      = RW'(DIV_ODD << 1);
  // Numerators at or above this bound give a quotient beyond QW bits.
  localparam logic [W-1:0]   LIMIT   = W'(DIV_ODD) << (SH + QW);

  logic [MW-1:0] m_c;
  logic [31:0]   mh_c;
  logic [RW-1:0] qd_c;
  logic [1:0]    corr_c;

  logic          ovf1_r;
  logic          ovf2_r;
  logic          ovf3_r;
  logic [QW-1:0] q1_r;
  logic [QW-1:0] q2_r;
  logic [QW-1:0] q3_r;
  logic [QW-1:0] q4_r;
  logic [RW-1:0] m1_r;
  logic [RW-1:0] m2_r;
  logic [RW-1:0] plo2_r;
  logic [RW-1:0] phi2_r;
  logic [RW-1:0] r3_r;

  // Drop the power of two; the top 32 bits feed the reciprocal multiply.
  assign m_c  = n_i[SH +: MW];
  assign mh_c = m_c[MW-1 -: 32];

  // Stage 1: range check and estimated quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf1_r <= (n_i >= LIMIT);
      m1_r   <= m_c[RW-1:0];
      q1_r   <= QW'((51'(mh_c) * 51'(RECIP)) >> 32);
    end
  end

  // Stage 2: estimated quotient times the odd divisor, in two halves.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf2_r <= ovf1_r;
      m2_r   <= m1_r;
      q2_r   <= q1_r;
      plo2_r <= RW'(50'(q1_r) * 50'(D_LO));
      phi2_r <= RW'(50'(q1_r) * 50'(D_HI));
    end
  end

  assign qd_c = RW'({phi2_r, 32'd0}) + plo2_r;

  // Stage 3: remainder of the estimate, below three divisors.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf3_r <= ovf2_r;
      q3_r   <= q2_r;
      r3_r   <= m2_r - qd_c;
    end
  end

  // The estimate is short by as many divisors as the remainder holds.
  always_comb begin
    priority if (r3_r >= D2) begin
      corr_c = 2'd2;
    end else if (r3_r >= D1) begin
      corr_c = 2'd1;
    end else begin
      corr_c = 2'd0;
    end
  end

  // Stage 4: corrected quotient, saturated when the range check failed.
  always_ff @(posedge clk) begin
    if (en) begin
      q4_r <= ovf3_r ? '1 : (q3_r + QW'(corr_c));
    end
  end

  assign q_o = q4_r;

endmodule

FILE: design/vp_to_vs_and_density.sv
// ============================================================================
// vp_to_vs_and_density: P-wave velocity to S-wave velocity and density
// Streams one velocity sample per transfer and returns vs and density.
// ============================================================================
// One result comes back for every input transfer, in order, and a new sample
// is taken on every cycle in which the result side is not stalled. The
// polynomials are evaluated exactly in scaled integers by Horner steps, each
// step a split 14 x 32 bit multiply stage and an add stage; both results are
// then divided by their constant scale in a four-stage divider that shifts
// out the power of two and divides the odd part by a reciprocal multiply with
// a remainder correction. The whole pipeline holds while a finished result
// waits on out_tready, so nothing is lost or repeated. Velocities above
// 16383 m/s are taken as 16383; zero or negative velocity gives -1 in both
// fields with found low.
module vp_to_vs_and_density (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [vpvs_pkg::IN_TDATA_W-1:0]    in_tdata,   // [15:0] vp_mps
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [vpvs_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [18:0] vs_mps,
                                                         // [37:19] density_kgm3,
                                                         // [39:38] zero
  output logic                               out_tuser   // [0] found
);
  import vpvs_pkg::*;

  // Stage 9 feeds the dividers; their outputs line up with the last stage.
  localparam int unsigned NPIPE = 9 + DIV_LAT;

  logic pipe_en;

  // Valid and flag bits traveling with the data.
  logic vld_r  [1:NPIPE];
  logic pos_r  [1:NPIPE];
  logic tpos_r [8:NPIPE];

  // Horner chain: index 0 is the first stage, index k+1 follows step k.
  logic [13:0] vsum_r  [0:3];
  acc_t        acc_a_r [0:3];
  acc_t        acc_d_r [0:3];
  logic [13:0] vm_r    [0:2];
  pp_lo_t      alo_r   [0:2];
  pp_hi_t      ahi_r   [0:2];
  pp_lo_t      dlo_r   [0:2];
  pp_hi_t      dhi_r   [0:2];

  // Final density product stages.
  logic [63:0] nvs8_r;
  pp_lo_t      plo8_r;
  pp_hi_t      phi8_r;
  logic [63:0] nvs9_r;
  logic [79:0] nrho9_r;

  logic [QW-1:0] q_vs;
  logic [QW-1:0] q_rho;

  // Input stage decode.
  logic signed [15:0] vp_in;
  logic               pos_c;
  logic [13:0]        v_c;

  // Output register.
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tuser_r;
  logic [OUT_TDATA_W-1:0] out_tdata_nxt;
  logic [OUT_FIELD_W-1:0] vs_fld;
  logic [OUT_FIELD_W-1:0] rho_fld;

  // The pipeline moves whenever the output register is empty or drained.
  assign pipe_en   = !out_valid_r || out_tready;
  assign in_tready = pipe_en;

  // Clamp the incoming velocity and flag the not-found case.
  always_comb begin
    vp_in = signed'(in_tdata[15:0]);
    pos_c = (vp_in > 16'sd0);
    if (vp_in > VP_LIMIT) begin
      v_c = VP_LIMIT_U;
    end else begin
      v_c = vp_in[13:0];
    end
  end

  // Valid bits and the found flag along the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= NPIPE; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (pipe_en) begin
      vld_r[1] <= in_tvalid;
      for (int i = 2; i <= NPIPE; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pos_r[1] <= pos_c;
      for (int i = 2; i <= NPIPE; i++) begin
        pos_r[i] <= pos_r[i-1];
      end
      tpos_r[8] <= (acc_d_r[3] > 64'sd0);
      for (int i = 9; i <= NPIPE; i++) begin
        tpos_r[i] <= tpos_r[i-1];
      end
    end
  end

  // Stage 1: first Horner terms, 64 v - 1238000 and 106 v - 4300000.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      vsum_r[0]  <= v_c;
      acc_a_r[0] <= signed'({44'd0, v_c, 6'd0}) - C_A1;
      acc_d_r[0] <= signed'({43'd0, 21'(v_c) * 21'd106}) - C_T1;
    end
  end

  // Stages 2 to 7: three Horner steps, multiply then add.
  for (genvar k = 0; k < 3; k++) begin : g_horner
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        vm_r[k]  <= vsum_r[k];
        alo_r[k] <= pp_lo(vsum_r[k], acc_a_r[k]);
        ahi_r[k] <= pp_hi(vsum_r[k], acc_a_r[k]);
        dlo_r[k] <= pp_lo(vsum_r[k], acc_d_r[k]);
        dhi_r[k] <= pp_hi(vsum_r[k], acc_d_r[k]);
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        vsum_r[k+1]  <= vm_r[k];
        acc_a_r[k+1] <= C_A[k] + acc_t'(pp_sum(ahi_r[k], alo_r[k]));
        acc_d_r[k+1] <= C_D[k] + acc_t'(pp_sum(dhi_r[k], dlo_r[k]));
      end
    end
  end

  // Stages 8 and 9: density numerator v * t plus rounding half.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      nvs8_r  <= acc_a_r[3];
      plo8_r  <= pp_lo(vsum_r[3], acc_d_r[3]);
      phi8_r  <= pp_hi(vsum_r[3], acc_d_r[3]);
      nvs9_r  <= nvs8_r;
      nrho9_r <= 80'(pp_sum(phi8_r, plo8_r)) + C_RHO_HALF;
    end
  end

  // Constant dividers for both results.
  vpvs_cdiv #(
    .W       (64),
    .SH      (DIV_VS_SH),
    .DIV_ODD (DIV_VS_ODD)
  ) u_div_vs (
    .clk (clk),
    .en  (pipe_en),
    .n_i (nvs9_r),
    .q_o (q_vs)
  );

  vpvs_cdiv #(
    .W       (80),
    .SH      (DIV_RHO_SH),
    .DIV_ODD (DIV_RHO_ODD)
  ) u_div_rho (
    .clk (clk),
    .en  (pipe_en),
    .n_i (nrho9_r),
    .q_o (q_rho)
  );

  // Result formatting: not-found marker and density floor.
  always_comb begin
    if (pos_r[NPIPE]) begin
      vs_fld = {1'b0, q_vs};
    end else begin
      vs_fld = '1;
    end

    priority if (!pos_r[NPIPE]) begin
      rho_fld = '1;
    end else if (!tpos_r[NPIPE] || (q_rho < RHO_FLOOR_Q)) begin
      rho_fld = RHO_FLOOR;
    end else begin
      rho_fld = {1'b0, q_rho};
    end

    out_tdata_nxt = {2'b00, rho_fld, vs_fld};
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= vld_r[NPIPE];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= pos_r[NPIPE];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
